>>> rtl/prng_keystream_xor_cipher_core_defines.svh
// Assertion macros shared by the keystream cipher RTL.
`ifndef PRNG_KEYSTREAM_XOR_CIPHER_CORE_DEFINES_SVH
`define PRNG_KEYSTREAM_XOR_CIPHER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PKXC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PKXC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pkxc_pkg.sv
// Package with the generator state type and the generator step functions.
`timescale 1ns / 1ps
package pkxc_pkg;

  localparam int unsigned WARMUP_ROUNDS_DEF = 20;
  localparam int unsigned DATA_W            = 8;
  localparam int unsigned WORD_W            = 32;

  localparam logic [WORD_W-1:0] RELOAD_A   = 32'habad1dea;
  localparam logic [WORD_W-1:0] RELOAD_B_K = 32'hc001d00d;
  localparam logic [WORD_W-1:0] RELOAD_C_K = 32'h5a5a5a5a;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } gen_state_t;

  // One generator step. Rotations are fixed: left by 27, 17 and 3.
  function automatic gen_state_t gen_step(input gen_state_t s);
    gen_state_t        n;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] t;
    e   = s.a + {s.b[4:0], s.b[31:5]};
    n.a = s.b - {s.c[14:0], s.c[31:15]};
    n.b = s.c ^ s.d;
    n.c = s.d - e;
    t   = e + n.a;
    n.d = e + {t[28:0], t[31:29]};
    return n;
  endfunction

  // Generator words loaded from the seed before the warm-up rounds.
  function automatic gen_state_t gen_reload(input logic [WORD_W-1:0] seed);
    gen_state_t n;
    n.a = RELOAD_A;
    n.b = seed - RELOAD_B_K;
    n.c = seed + RELOAD_C_K;
    n.d = {seed[2:0], seed[31:3]};
    return n;
  endfunction

endpackage

>>> rtl/pkxc_warmup.sv
// Warm-up sequencer: keeps the generator state that a restart starts from.
`timescale 1ns / 1ps
module pkxc_warmup #(
  parameter int unsigned WarmupRounds = pkxc_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [pkxc_pkg::WORD_W-1:0]   cfg_wdata,
  output pkxc_pkg::gen_state_t          warm_state,
  output logic                          warm_done
);
  import pkxc_pkg::*;
  `include "prng_keystream_xor_cipher_core_defines.svh"

  localparam int unsigned CntW = (WarmupRounds < 1) ? 1 : $clog2(WarmupRounds + 1);

  gen_state_t        warm_r;
  gen_state_t        warm_nxt;
  logic [CntW-1:0]   cnt_r;
  logic [CntW-1:0]   cnt_nxt;

  // A new seed reloads the words and the rounds are then run one per cycle.
  always_comb begin
    warm_nxt = warm_r;
    cnt_nxt  = cnt_r;
    if (cfg_wen) begin
      warm_nxt = gen_reload(cfg_wdata);
      cnt_nxt  = CntW'(WarmupRounds);
    end else if (cnt_r != '0) begin
      warm_nxt = gen_step(warm_r);
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // The seed resets to zero, so warm up from a zero seed.
      warm_r <= gen_reload('0);
      cnt_r  <= CntW'(WarmupRounds);
    end else begin
      warm_r <= warm_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign warm_state = warm_r;
  assign warm_done  = (cnt_r == '0);

  `PKXC_ASSERT(a_cfg_restarts_warmup, clk, rst_n,
    cfg_wen |=> (cnt_r == CntW'(WarmupRounds)), "seed write did not restart warm-up")
  `PKXC_ASSERT(a_cnt_in_range, clk, rst_n,
    cnt_r <= CntW'(WarmupRounds), "warm-up count out of range")
  `PKXC_ASSERT(a_warm_holds_when_done, clk, rst_n,
    (warm_done && !cfg_wen) |=> $stable(warm_r), "warmed state moved after warm-up")

endmodule

>>> rtl/prng_keystream_xor_cipher_core.sv
// Top level of the seeded keystream XOR byte cipher.
`timescale 1ns / 1ps
// Byte-stream XOR cipher: each byte is XORed with the low byte of a four-word
// add-rotate-xor generator that advances one step per byte, so one byte is
// taken and one result produced every clock cycle unless out_tready or the
// warm-up holds it. A byte with in_tuser set restarts the keystream from the
// seed; the warmed-up restart state is kept ready in advance by a warm-up
// sequencer that runs one round per cycle. After reset and after every write
// of the seed that sequencer runs WarmupRounds rounds (20 by default), during
// which in_tready stays low. The same block encrypts and decrypts. Until the
// first restart the generator is all zero and bytes pass through unchanged.
module prng_keystream_xor_cipher_core #(
  parameter int unsigned WarmupRounds = pkxc_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [pkxc_pkg::WORD_W-1:0]   cfg_wdata,   // key_seed
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pkxc_pkg::DATA_W-1:0]   in_tdata,    // [7:0] data_byte
  input  logic                          in_tuser,    // [0] restart_key
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pkxc_pkg::DATA_W-1:0]   out_tdata    // [7:0] out_byte
);
  import pkxc_pkg::*;
  `include "prng_keystream_xor_cipher_core_defines.svh"

  gen_state_t              warm_state;
  logic                    warm_done;
  gen_state_t              gen_r;
  gen_state_t              gen_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [DATA_W-1:0]       out_data_r;
  logic [DATA_W-1:0]       out_data_nxt;
  logic                    in_xfer;

  pkxc_warmup #(
    .WarmupRounds (WarmupRounds)
  ) u_warmup (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .warm_state (warm_state),
    .warm_done  (warm_done)
  );

  assign in_tready = warm_done && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    gen_nxt       = gen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_xfer) begin
      gen_nxt       = gen_step(in_tuser ? warm_state : gen_r);
      out_valid_nxt = 1'b1;
      out_data_nxt  = in_tdata ^ gen_nxt.d[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PKXC_ASSERT(a_no_accept_in_warmup, clk, rst_n,
    !warm_done |-> !in_tready, "input taken while warm-up runs")
  `PKXC_ASSERT(a_accept_gives_result, clk, rst_n,
    in_xfer |=> out_tvalid, "accepted byte produced no result")
  `PKXC_ASSERT(a_restart_from_warm, clk, rst_n,
    (in_xfer && in_tuser) |=> (gen_r == gen_step($past(warm_state))),
    "restart did not start from warmed state")
  `PKXC_ASSERT(a_state_holds_idle, clk, rst_n,
    !in_xfer |=> $stable(gen_r), "generator moved without a byte")

endmodule
